[rtl/pfac_pkg.sv]
// ----------------------------------------------------------------------------
// pfac_pkg: shared types and constants of the pressure and flow alarm
// Holds the alarm level codes, the register indexes, the configuration
// bundle and the work item that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package pfac_pkg;

    localparam int TimeW = 48;

    // Alarm level codes as they appear on the result channel.
    localparam logic [1:0] LVL_NORMAL  = 2'd0;
    localparam logic [1:0] LVL_WARNING = 2'd1;
    localparam logic [1:0] LVL_ALERT   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_PRESSURE_LOW  = 3'd0;
    localparam logic [2:0] REG_PRESSURE_HIGH = 3'd1;
    localparam logic [2:0] REG_FLOW_THRESH   = 3'd2;
    localparam logic [2:0] REG_FLOW_WINDOW   = 3'd3;
    localparam logic [2:0] REG_ALERT_TONE    = 3'd4;
    localparam logic [2:0] REG_WARN_TONE     = 3'd5;
    localparam logic [2:0] REG_ALERT_MUTE    = 3'd6;
    localparam logic [2:0] REG_WARN_MUTE     = 3'd7;

    // Alert margin of 15.0 in Q11.4, and beep half periods in microseconds.
    localparam logic signed [17:0] ALERT_MARGIN = 18'sd240;
    localparam logic [TimeW-1:0] ALERT_TOGGLE_US = 48'd150000;
    localparam logic [TimeW-1:0] WARN_TOGGLE_US  = 48'd500000;

    localparam logic [25:0] US_PER_MS = 26'd1000;
    localparam logic [35:0] US_PER_S  = 36'd1000000;

    // Window and mute lengths are kept in microseconds, scaled at write time.
    typedef struct packed {
        logic signed [15:0] pressure_low;
        logic signed [15:0] pressure_high;
        logic [14:0]        flow_thresh;
        logic [25:0]        flow_window_us;
        logic               alert_tone;
        logic               warn_tone;
        logic [35:0]        alert_mute_us;
        logic [35:0]        warn_mute_us;
    } cfg_t;

    // One classified item waiting for the back end.
    typedef struct packed {
        logic               mode;
        logic [TimeW-1:0]   now_us;
        logic signed [15:0] flow;
        logic               press_alert;
        logic               press_warn;
        logic [TimeW-1:0]   mute_end_alert;
        logic [TimeW-1:0]   mute_end_warn;
    } item_t;

endpackage

[rtl/pfac_cfg.sv]
// ----------------------------------------------------------------------------
// pfac_cfg: configuration registers
// Takes register writes and keeps time lengths pre-scaled to microseconds.
// ----------------------------------------------------------------------------
module pfac_cfg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [2:0]        wr_addr,
    input  logic [15:0]       wr_data,
    output pfac_pkg::cfg_t    cfg
);
    import pfac_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_addr)
                REG_PRESSURE_LOW:  cfg_next.pressure_low   = signed'(wr_data);
                REG_PRESSURE_HIGH: cfg_next.pressure_high  = signed'(wr_data);
                REG_FLOW_THRESH:   cfg_next.flow_thresh    = wr_data[14:0];
                REG_FLOW_WINDOW:   cfg_next.flow_window_us = 26'(wr_data) * US_PER_MS;
                REG_ALERT_TONE:    cfg_next.alert_tone     = wr_data[0];
                REG_WARN_TONE:     cfg_next.warn_tone      = wr_data[0];
                REG_ALERT_MUTE:    cfg_next.alert_mute_us  = 36'(wr_data) * US_PER_S;
                REG_WARN_MUTE:     cfg_next.warn_mute_us   = 36'(wr_data) * US_PER_S;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pressure_low   <= '0;
            cfg_reg.pressure_high  <= '0;
            cfg_reg.flow_thresh    <= '0;
            cfg_reg.flow_window_us <= 26'd1000000;
            cfg_reg.alert_tone     <= 1'b1;
            cfg_reg.warn_tone      <= 1'b1;
            cfg_reg.alert_mute_us  <= 36'd120000000;
            cfg_reg.warn_mute_us   <= 36'd120000000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/pfac_front.sv]
// ----------------------------------------------------------------------------
// pfac_front: item classifier
// Compares pressure against the limits and works out both possible mute end
// times, none of which depends on the alarm state.
// ----------------------------------------------------------------------------
module pfac_front (
    input  logic                   mode,
    input  logic [47:0]            now_us,
    input  logic signed [15:0]     pressure_sample,
    input  logic signed [15:0]     flow_sample,
    input  pfac_pkg::cfg_t         cfg,
    output pfac_pkg::item_t        item
);
    import pfac_pkg::*;

    logic signed [17:0] p_ext;
    logic signed [17:0] low_ext;
    logic signed [17:0] high_ext;
    logic [TimeW:0]     end_alert_sum;
    logic [TimeW:0]     end_warn_sum;

    assign p_ext    = {{2{pressure_sample[15]}}, pressure_sample};
    assign low_ext  = {{2{cfg.pressure_low[15]}}, cfg.pressure_low};
    assign high_ext = {{2{cfg.pressure_high[15]}}, cfg.pressure_high};

    assign end_alert_sum = {1'b0, now_us} + 49'(cfg.alert_mute_us);
    assign end_warn_sum  = {1'b0, now_us} + 49'(cfg.warn_mute_us);

    always_comb begin
        item.mode        = mode;
        item.now_us      = now_us;
        item.flow        = flow_sample;
        item.press_alert = (p_ext < low_ext - ALERT_MARGIN) ||
                           (p_ext > high_ext + ALERT_MARGIN);
        item.press_warn  = (p_ext < low_ext) || (p_ext > high_ext);
        // The end time saturates at the largest 48-bit value.
        item.mute_end_alert = end_alert_sum[TimeW] ? '1 : end_alert_sum[TimeW-1:0];
        item.mute_end_warn  = end_warn_sum[TimeW]  ? '1 : end_warn_sum[TimeW-1:0];
    end

endmodule

[rtl/pfac_queue.sv]
// ----------------------------------------------------------------------------
// pfac_queue: two-entry queue between front end and back end
// Lets the input side keep accepting while the back end waits on the output.
// ----------------------------------------------------------------------------
module pfac_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  pfac_pkg::item_t   push_item,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output pfac_pkg::item_t   head_item
);
    import pfac_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/pfac_back.sv]
// ----------------------------------------------------------------------------
// pfac_back: alarm state update
// Holds the alarm state, applies one queued item per cycle while the result
// register is empty or being taken, and drives the result register.
// ----------------------------------------------------------------------------
module pfac_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  pfac_pkg::cfg_t    cfg,
    input  logic              item_valid,
    input  pfac_pkg::item_t   item,
    output logic              item_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata
);
    import pfac_pkg::*;

    logic [1:0]         level_reg,        level_next;
    logic               mute_reg,         mute_next;
    logic [TimeW-1:0]   mute_end_reg,     mute_end_next;
    logic [TimeW-1:0]   last_toggle_reg,  last_toggle_next;
    logic               phase_reg,        phase_next;
    logic               buzzer_reg,       buzzer_next;
    logic signed [15:0] base_flow_reg,    base_flow_next;
    logic [TimeW-1:0]   base_start_reg,   base_start_next;
    logic               base_present_reg, base_present_next;
    logic               out_valid_reg,    out_valid_next;
    logic [7:0]         out_data_reg,     out_data_next;

    logic               restart;
    logic [TimeW-1:0]   base_elapsed;
    logic [TimeW-1:0]   toggle_elapsed;
    logic [TimeW-1:0]   toggle_iv;
    logic signed [16:0] flow_diff;
    logic [16:0]        flow_abs;
    logic               flow_warn;
    logic [1:0]         target;
    logic               mute_kept;
    logic               tone;

    assign item_pop = item_valid && (!out_valid_reg || m_tready);

    assign base_elapsed   = item.now_us - base_start_reg;
    assign toggle_elapsed = item.now_us - last_toggle_reg;
    assign flow_diff      = {item.flow[15], item.flow} - {base_flow_reg[15], base_flow_reg};
    assign flow_abs       = flow_diff[16] ? 17'(-flow_diff) : 17'(flow_diff);

    always_comb begin
        level_next        = level_reg;
        mute_next         = mute_reg;
        mute_end_next     = mute_end_reg;
        last_toggle_next  = last_toggle_reg;
        phase_next        = phase_reg;
        buzzer_next       = buzzer_reg;
        base_flow_next    = base_flow_reg;
        base_start_next   = base_start_reg;
        base_present_next = base_present_reg;

        restart = !base_present_reg || (item.now_us < base_start_reg) ||
                  (base_elapsed >= 48'(cfg.flow_window_us));
        flow_warn = !restart && (flow_abs > 17'(cfg.flow_thresh));

        if (item.press_alert) begin
            target = LVL_ALERT;
        end else if (item.press_warn || flow_warn) begin
            target = LVL_WARNING;
        end else begin
            target = LVL_NORMAL;
        end

        // Escalation from warning to alert breaks the mute, then it may expire.
        mute_kept = mute_reg && !(target == LVL_ALERT && level_reg == LVL_WARNING) &&
                    (item.now_us < mute_end_reg);
        toggle_iv = (target == LVL_ALERT) ? ALERT_TOGGLE_US : WARN_TOGGLE_US;
        tone      = (target == LVL_ALERT) ? cfg.alert_tone : cfg.warn_tone;

        if (item.mode) begin
            if (level_reg != LVL_NORMAL) begin
                mute_next     = 1'b1;
                mute_end_next = (level_reg == LVL_ALERT) ? item.mute_end_alert
                                                         : item.mute_end_warn;
                buzzer_next   = 1'b0;
            end
        end else begin
            if (restart) begin
                base_flow_next    = item.flow;
                base_start_next   = item.now_us;
                base_present_next = 1'b1;
            end
            level_next = target;
            mute_next  = mute_kept;
            if (target == LVL_NORMAL || mute_kept) begin
                buzzer_next = 1'b0;
            end else if (item.now_us >= last_toggle_reg && toggle_elapsed >= toggle_iv) begin
                phase_next       = ~phase_reg;
                last_toggle_next = item.now_us;
                buzzer_next      = ~phase_reg & tone;
            end
        end

        out_valid_next = item_pop ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_data_next  = item_pop ? {4'b0, buzzer_next, mute_next, level_next} : out_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mute_end_reg    <= '0;
            last_toggle_reg <= '0;
            base_flow_reg   <= '0;
            base_start_reg  <= '0;
        end else if (item_pop) begin
            mute_end_reg    <= mute_end_next;
            last_toggle_reg <= last_toggle_next;
            base_flow_reg   <= base_flow_next;
            base_start_reg  <= base_start_next;
        end
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg        <= LVL_NORMAL;
            mute_reg         <= 1'b0;
            phase_reg        <= 1'b0;
            buzzer_reg       <= 1'b0;
            base_present_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (item_pop) begin
                level_reg        <= level_next;
                mute_reg         <= mute_next;
                phase_reg        <= phase_next;
                buzzer_reg       <= buzzer_next;
                base_present_reg <= base_present_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[rtl/pressure_flow_alarm_controller.sv]
// ----------------------------------------------------------------------------
// pressure_flow_alarm_controller: pressure and flow alarm with mute and beep
// Classifies timestamped pressure and flow samples, handles mute presses and
// produces the alarm level, mute flag and buzzer drive for each transaction.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel (s_tvalid, s_tready, s_tdata, s_tuser) takes one item per
// transaction. s_tuser carries the mode: 0 for a pressure and flow sample,
// 1 for a press of the mute button. Every accepted transaction produces
// exactly one result transaction on the master channel, in order.
// The configuration channel (cfg_valid, cfg_ready, cfg_addr, cfg_wdata)
// writes one register per transaction; write only while the block is idle.
// Time lengths are scaled to microseconds as they are written.
// A result passes through the queue and then the output register before it is
// valid on the master channel. Throughput is one item per cycle while the
// receiver takes results, set by the state update in the back end.
// A front end classifies pressure and computes mute end times, a two-entry
// queue decouples it from the back end, and the back end owns the alarm state
// and an output register. When the receiver stalls the output register holds
// its result, the queue absorbs two more items and s_tready then drops.
// Synchronous reset (aresetn low) restores the register defaults, clears the
// alarm state and empties the queue and output register.
// ----------------------------------------------------------------------------
module pressure_flow_alarm_controller (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: now_us [47:0], pressure_sample [63:48], flow_sample [79:64].
    input  logic [79:0] s_tdata,
    // Fields from bit 0: mode [0].
    input  logic [0:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: alarm_level [1:0], muted_flag [2], buzzer_drive [3], zero [7:4].
    output logic [7:0]  m_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import pfac_pkg::*;

    cfg_t  cfg;
    item_t front_item;
    item_t head_item;
    logic  queue_full;
    logic  queue_not_empty;
    logic  queue_pop;
    logic  s_accept;

    // Registers are always ready to take a write.
    assign cfg_ready = 1'b1;

    assign s_tready = !queue_full;
    assign s_accept = s_tvalid && s_tready;

    pfac_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_valid && cfg_ready),
        .wr_addr (cfg_addr),
        .wr_data (cfg_wdata),
        .cfg     (cfg)
    );

    pfac_front u_front (
        .mode            (s_tuser[0]),
        .now_us          (s_tdata[47:0]),
        .pressure_sample (signed'(s_tdata[63:48])),
        .flow_sample     (signed'(s_tdata[79:64])),
        .cfg             (cfg),
        .item            (front_item)
    );

    pfac_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_accept),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .head_item (head_item)
    );

    pfac_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (queue_not_empty),
        .item       (head_item),
        .item_pop   (queue_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

[rtl/pfac_checker.sv]
// ----------------------------------------------------------------------------
// pfac_checker: port-level checks of the alarm controller
// Watches the result channel for reset behavior, legal level codes, a buzzer
// that only sounds while an alarm is active and unmuted, and stable stalled results.
// ----------------------------------------------------------------------------
module pfac_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    import pfac_pkg::*;

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_level_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == LVL_NORMAL || m_tdata[1:0] == LVL_WARNING ||
                      m_tdata[1:0] == LVL_ALERT))
        else $error("illegal alarm level");

    // A sounding buzzer means an active, unmuted alarm.
    a_buzzer_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |-> (!m_tdata[2] && m_tdata[1:0] != LVL_NORMAL))
        else $error("buzzer on while muted or normal");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind pressure_flow_alarm_controller pfac_checker u_pfac_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/pressure_flow_alarm_controller_tb.sv]
// ----------------------------------------------------------------------------
// pressure_flow_alarm_controller_tb: self-checking bench for the alarm block
// Streams timestamped pressure and flow samples and mute presses into the
// block and keeps its own copy of the alarm state. Each result transaction is
// compared field by field against the level, mute flag and buzzer drive that
// this bench works out. Handshake pressure is varied on both channels and the
// configuration is changed between bursts while the block is idle.
// ----------------------------------------------------------------------------
module pressure_flow_alarm_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfac_pkg::*;

    // Item kinds carried on s_tuser.
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_MUTE   = 1'b1;

    // Alert margin of 15.0 in Q11.4, beep half periods and unit scales.
    localparam int          PRESSURE_MARGIN = 240;
    localparam logic [63:0] BEEP_ALERT_US   = 64'd150000;
    localparam logic [63:0] BEEP_WARN_US    = 64'd500000;
    localparam logic [63:0] USEC_PER_MSEC   = 64'd1000;
    localparam logic [63:0] USEC_PER_SEC    = 64'd1000000;
    localparam logic [63:0] TIME_MAX        = 64'hFFFF_FFFF_FFFF;

    // What one result transaction is expected to carry.
    typedef struct packed {
        logic [1:0] level;
        logic       muted;
        logic       buzzer;
    } alarm_result_t;

    // The alarm state as the block should hold it, plus the results that
    // accepted items have caused and that have not been seen yet.
    class alarm_predictor;
        logic signed [15:0] low_limit;
        logic signed [15:0] high_limit;
        logic [14:0]        flow_thresh;
        logic [15:0]        window_ms;
        logic               alert_tone;
        logic               warn_tone;
        logic [15:0]        alert_mute_s;
        logic [15:0]        warn_mute_s;

        logic [1:0]         level;
        logic               muted;
        logic [47:0]        mute_end;
        logic [47:0]        last_toggle;
        logic               beep_phase;
        logic               buzzer;
        logic signed [15:0] base_flow;
        logic [47:0]        base_start;
        logic               base_valid;

        alarm_result_t      expected_alarms[$];
        int                 errors;
        int                 shown;

        function new();
            low_limit    = '0;
            high_limit   = '0;
            flow_thresh  = '0;
            window_ms    = 16'd1000;
            alert_tone   = 1'b1;
            warn_tone    = 1'b1;
            alert_mute_s = 16'd120;
            warn_mute_s  = 16'd120;
            level        = LVL_NORMAL;
            muted        = 1'b0;
            mute_end     = '0;
            last_toggle  = '0;
            beep_phase   = 1'b0;
            buzzer       = 1'b0;
            base_flow    = '0;
            base_start   = '0;
            base_valid   = 1'b0;
            errors       = 0;
            shown        = 0;
        endfunction

        function void write_reg(logic [2:0] index, logic [15:0] value);
            case (index)
                REG_PRESSURE_LOW:  low_limit    = value;
                REG_PRESSURE_HIGH: high_limit   = value;
                REG_FLOW_THRESH:   flow_thresh  = value[14:0];
                REG_FLOW_WINDOW:   window_ms    = value;
                REG_ALERT_TONE:    alert_tone   = value[0];
                REG_WARN_TONE:     warn_tone    = value[0];
                REG_ALERT_MUTE:    alert_mute_s = value;
                REG_WARN_MUTE:     warn_mute_s  = value;
                default: ;
            endcase
        endfunction

        // Advances the alarm state by one accepted item and queues the result.
        function void note_item(logic mode, logic [47:0] now,
                                logic signed [15:0] pressure, logic signed [15:0] flow);
            logic [63:0]   mute_until;
            logic [63:0]   window_us;
            logic [63:0]   interval;
            logic [15:0]   secs;
            logic [1:0]    target;
            logic          flow_warn;
            int            p;
            int            lo;
            int            hi;
            int            diff;
            int            thr;
            alarm_result_t res;

            if (mode == MODE_MUTE) begin
                if (level != LVL_NORMAL) begin
                    secs = (level == LVL_ALERT) ? alert_mute_s : warn_mute_s;
                    mute_until = {16'd0, now} + secs * USEC_PER_SEC;
                    if (mute_until > TIME_MAX)
                        mute_until = TIME_MAX;
                    muted    = 1'b1;
                    mute_end = mute_until[47:0];
                    buzzer   = 1'b0;
                end
            end else begin
                flow_warn = 1'b0;
                window_us = window_ms * USEC_PER_MSEC;
                // A missing, stale or future-dated baseline is replaced.
                if (!base_valid || now < base_start ||
                    ({16'd0, now} - {16'd0, base_start}) >= window_us) begin
                    base_flow  = flow;
                    base_start = now;
                    base_valid = 1'b1;
                end else begin
                    diff = int'(flow) - int'(base_flow);
                    if (diff < 0)
                        diff = -diff;
                    thr = int'(flow_thresh);
                    flow_warn = (diff > thr);
                end

                p  = int'(pressure);
                lo = int'(low_limit);
                hi = int'(high_limit);
                if (p < lo - PRESSURE_MARGIN || p > hi + PRESSURE_MARGIN)
                    target = LVL_ALERT;
                else if (p < lo || p > hi || flow_warn)
                    target = LVL_WARNING;
                else
                    target = LVL_NORMAL;

                if (target == LVL_ALERT && level == LVL_WARNING)
                    muted = 1'b0;
                level = target;

                if (muted && now >= mute_end)
                    muted = 1'b0;

                if (level == LVL_NORMAL || muted) begin
                    buzzer = 1'b0;
                end else begin
                    interval = (level == LVL_ALERT) ? BEEP_ALERT_US : BEEP_WARN_US;
                    if (now >= last_toggle &&
                        ({16'd0, now} - {16'd0, last_toggle}) >= interval) begin
                        beep_phase  = ~beep_phase;
                        last_toggle = now;
                        buzzer = beep_phase & ((level == LVL_ALERT) ? alert_tone : warn_tone);
                    end
                end
            end

            res.level  = level;
            res.muted  = muted;
            res.buzzer = buzzer;
            expected_alarms.push_back(res);
        endfunction

        function void mismatch(string field, int want, int got);
            errors++;
            if (shown < 40)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            shown++;
        endfunction

        function void check_result(logic [7:0] data);
            alarm_result_t want;
            if (expected_alarms.size() == 0) begin
                errors++;
                if (shown < 40)
                    $display("%0t: result with nothing expected, actual 0x%02h", $time, data);
                shown++;
            end else begin
                want = expected_alarms.pop_front();
                if (data[1:0] != want.level)
                    mismatch("alarm_level", int'(want.level), int'(data[1:0]));
                if (data[2] != want.muted)
                    mismatch("muted_flag", int'(want.muted), int'(data[2]));
                if (data[3] != want.buzzer)
                    mismatch("buzzer_drive", int'(want.buzzer), int'(data[3]));
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn   = 1'b0;

    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // Fields from bit 0: now_us [47:0], pressure_sample [63:48], flow_sample [79:64].
    logic [79:0] s_tdata   = '0;
    // Fields from bit 0: mode [0].
    logic [0:0]  s_tuser   = '0;

    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // Fields from bit 0: alarm_level [1:0], muted_flag [2], buzzer_drive [3], zero [7:4].
    logic [7:0]  m_tdata;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_addr  = '0;
    logic [15:0] cfg_wdata = '0;

    // Handshake pressure knobs, in percent of cycles spent idle.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // Cycles the receiver still has to hold off; set by the stimulus, counted
    // down by the receiver process.
    int recv_hold = 0;

    // Running timestamp of the random stimulus.
    logic [47:0] stim_now;

    alarm_predictor pred;

    pressure_flow_alarm_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 50 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case a handshake never completes or a result never shows.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Receiver side: either a long hold-off requested by the stimulus, or a
    // random stall pattern with the current idle percentage.
    always @(posedge aclk) begin
        if (recv_hold > 0) begin
            m_tready <= 1'b0;
            recv_hold = recv_hold - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: every completed transaction on the three channels is seen here,
    // at the clock edge where it happens. Register writes and input items feed
    // the predictor; results are checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                pred.write_reg(cfg_addr, cfg_wdata);
            if (s_tvalid && s_tready)
                pred.note_item(s_tuser[0], s_tdata[47:0], s_tdata[63:48], s_tdata[79:64]);
            if (m_tvalid && m_tready)
                pred.check_result(m_tdata);
        end
    end

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Offers one item and waits for its transaction. Afterwards the sender may
    // idle for a random number of cycles; valid stays high when it does not,
    // so back-to-back items never lower and raise valid in one time step.
    task automatic send_item(logic mode, logic [47:0] now,
                             logic signed [15:0] pressure, logic signed [15:0] flow);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {flow, pressure, now};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stops the sender and waits until every expected result has arrived.
    // The first edge lets the monitor record an item accepted just before.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pred.expected_alarms.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // One register write transaction. Valid is left high so that consecutive
    // writes run back to back; the caller lowers it.
    task automatic write_reg(logic [2:0] index, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
    endtask

    task automatic program_all(logic [15:0] low, logic [15:0] high, logic [15:0] thresh,
                               logic [15:0] window, logic [15:0] a_tone, logic [15:0] w_tone,
                               logic [15:0] a_mute, logic [15:0] w_mute);
        write_reg(REG_PRESSURE_LOW, low);
        write_reg(REG_PRESSURE_HIGH, high);
        write_reg(REG_FLOW_THRESH, thresh);
        write_reg(REG_FLOW_WINDOW, window);
        write_reg(REG_ALERT_TONE, a_tone);
        write_reg(REG_WARN_TONE, w_tone);
        write_reg(REG_ALERT_MUTE, a_mute);
        write_reg(REG_WARN_MUTE, w_mute);
        cfg_valid <= 1'b0;
    endtask

    // Random items. Time mostly moves forward in steps that straddle the beep
    // intervals, flow windows and mute lengths, with occasional backward steps
    // and jumps across the whole 48-bit range. Pressure is aimed at the bands
    // around the current limits and flow at the band around the baseline, so
    // that every level and the flow warning boundary are reached often.
    task automatic random_burst(int count);
        int                 r;
        int                 k;
        int                 pv;
        int                 fv;
        int                 lo;
        int                 hi;
        int                 b;
        int                 t;
        logic [63:0]        delta_us;
        logic               mode;
        logic signed [15:0] p;
        logic signed [15:0] f;

        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            delta_us = 0;
            if (r < 70)
                delta_us = 64'($urandom_range(0, 200000));
            else if (r < 85)
                delta_us = 64'($urandom_range(0, 3000000));
            else if (r < 92)
                delta_us = 64'($urandom_range(0, 10000000));
            else if (r < 95)
                stim_now = (stim_now > 48'd400000) ? stim_now - $urandom_range(1, 400000) : '0;
            else if (r < 97)
                stim_now = 48'({$urandom, $urandom});
            else if (r < 98)
                stim_now = TIME_MAX[47:0] - $urandom_range(0, 2000000);
            else
                stim_now = 48'($urandom_range(0, 1000));
            if ({16'd0, stim_now} + delta_us > TIME_MAX)
                stim_now = 48'($urandom_range(0, 1000));
            else
                stim_now = stim_now + delta_us[47:0];

            mode = ($urandom_range(99) < 20) ? MODE_MUTE : MODE_SAMPLE;

            lo = int'(pred.low_limit);
            hi = int'(pred.high_limit);
            k = $urandom_range(9);
            case (k)
                0, 1, 2, 3: begin
                    if (lo <= hi)
                        pv = lo + int'($urandom_range(0, hi - lo));
                    else
                        pv = int'($urandom_range(0, 65535)) - 32768;
                end
                4: pv = lo - int'($urandom_range(1, PRESSURE_MARGIN));
                5: pv = hi + int'($urandom_range(1, PRESSURE_MARGIN));
                6: pv = lo - PRESSURE_MARGIN - int'($urandom_range(1, 3000));
                7: pv = hi + PRESSURE_MARGIN + int'($urandom_range(1, 3000));
                8: begin
                    // Exact edges of the normal, warning and alert bands.
                    case ($urandom_range(7))
                        0: pv = lo;
                        1: pv = hi;
                        2: pv = lo - 1;
                        3: pv = hi + 1;
                        4: pv = lo - PRESSURE_MARGIN;
                        5: pv = hi + PRESSURE_MARGIN;
                        6: pv = lo - PRESSURE_MARGIN - 1;
                        default: pv = hi + PRESSURE_MARGIN + 1;
                    endcase
                end
                default: pv = int'($urandom_range(0, 65535)) - 32768;
            endcase

            b = int'(pred.base_flow);
            t = int'(pred.flow_thresh);
            k = $urandom_range(9);
            case (k)
                5: fv = b + t;
                6: fv = b - t;
                7: fv = b + t + 1;
                8: fv = b - t - 1;
                9: fv = int'($urandom_range(0, 65535)) - 32768;
                default: fv = b + int'($urandom_range(0, 2 * t + 16)) - (t + 8);
            endcase

            p = clamp16(pv);
            f = clamp16(fv);
            send_item(mode, stim_now, p, f);
        end
    endtask

    // Main sequence.
    initial begin
        int lo;
        int hi;

        pred = new();
        stim_now = '0;

        // Reset is held at the start and never asserted again.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Phase one: sender idles 35 percent, receiver 52 percent.
        send_idle_pct = 35;
        recv_idle_pct = 52;

        // Directed items with the reset configuration: limits at zero, flow
        // threshold zero, one second window, tones on, 120 s mutes.
        send_item(MODE_SAMPLE, 48'd0, 16'sd0, 16'sd0);           // first baseline
        send_item(MODE_SAMPLE, 48'd1000, 16'sd0, 16'sd5);        // flow change only
        send_item(MODE_SAMPLE, 48'd600000, 16'sd100, 16'sd5);    // warning, first beep
        send_item(MODE_MUTE, 48'd700000, 16'sd0, 16'sd0);        // mute at warning
        // Rise to alert breaks the mute; both fields at their extremes.
        send_item(MODE_SAMPLE, 48'd800000, 16'sh7FFF, 16'sh8000);
        send_item(MODE_SAMPLE, 48'd960000, 16'sh7FFF, 16'sd0);   // alert cadence
        send_item(MODE_MUTE, 48'd1000000, 16'sh7FFF, 16'sh7FFF); // mute at alert
        send_item(MODE_SAMPLE, 48'd1100000, 16'sh8000, 16'sd0);  // window expired
        send_item(MODE_SAMPLE, 48'd1200000, 16'sd0, 16'sd0);     // back to normal
        send_item(MODE_MUTE, 48'd1200001, 16'sd0, 16'sd0);       // press at normal
        send_item(MODE_SAMPLE, 48'd122000000, 16'sd240, 16'sd0); // mute runs out
        send_item(MODE_SAMPLE, 48'd122600000, -16'sd240, 16'sd0);
        send_item(MODE_SAMPLE, 48'd122700000, -16'sd241, 16'sd0);
        // Time steps backward: new baseline, and no beep toggle.
        send_item(MODE_SAMPLE, 48'd50000, 16'sd0, 16'sd0);
        send_item(MODE_SAMPLE, 48'd60000, 16'sd300, 16'sd0);
        // Mute pressed near the top of the time range saturates its end time.
        send_item(MODE_MUTE, 48'hFFFF_FFFF_FFFA, 16'sd0, 16'sd0);
        send_item(MODE_SAMPLE, 48'hFFFF_FFFF_FFFF, 16'sd300, 16'sd0);
        send_item(MODE_SAMPLE, 48'hFFFF_FFFF_FFFF, -16'sd1, -16'sd1);
        send_item(MODE_MUTE, 48'hFFFF_FFFF_FFFF, -16'sd1, -16'sd1);
        wait_all_results();

        // Moderate limits with short mutes so that expiry is reached often.
        program_all(-16'sd400, 16'sd400, 16'd64, 16'd500, 16'd1, 16'd1, 16'd1, 16'd2);
        random_burst(75);
        // Long receiver hold-off while items keep coming: the block fills up
        // and must stall its input without losing anything.
        recv_hold = 300;
        random_burst(75);
        wait_all_results();

        // Phase two: idling the other way round.
        send_idle_pct = 52;
        recv_idle_pct = 35;

        // Inverted extreme limits, zero window (every sample is a new
        // baseline), zero alert mute and the longest warning mute.
        program_all(16'h7FFF, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'hFFFF);
        random_burst(75);
        // Sender pauses until every result is back, then resumes.
        wait_all_results();
        random_burst(75);
        wait_all_results();

        // Phase three: no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Widest limits, largest threshold and window, longest alert mute.
        program_all(16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 16'd0);
        random_burst(150);
        wait_all_results();

        // A random everyday setting.
        lo = -int'($urandom_range(0, 2000));
        hi = lo + int'($urandom_range(0, 3000));
        program_all(lo[15:0], hi[15:0], 16'($urandom_range(0, 500)),
                    16'($urandom_range(0, 3000)), 16'($urandom_range(0, 1)),
                    16'($urandom_range(0, 1)), 16'($urandom_range(0, 5)),
                    16'($urandom_range(0, 5)));
        random_burst(150);
        wait_all_results();

        repeat (10) @(posedge aclk);
        if (pred.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
rtl/pfac_pkg.sv
rtl/pfac_cfg.sv
rtl/pfac_front.sv
rtl/pfac_queue.sv
rtl/pfac_back.sv
rtl/pressure_flow_alarm_controller.sv
rtl/pfac_checker.sv
tb/sv/pressure_flow_alarm_controller_tb.sv
